// File: src/epi_pkg.sv
`timescale 1ns / 1ps

package epi_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int HASH_SLOTS      = 4096;

	localparam int SLOT_W  = $clog2(HASH_SLOTS);
	localparam int PAL_W   = $clog2(PALETTE_ENTRIES);
	localparam int COUNT_W = $clog2(PALETTE_ENTRIES + 1);
	localparam int IDX_W   = 8;
	localparam int CNT_W   = 9;
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 3 * CHAN_W;
	localparam int DIST_W  = 18;
	localparam int EPOCH_W = 8;

	localparam logic [31:0]       HASH_MULT    = 32'd2654435761;
	localparam logic [SLOT_W-1:0] HASH_MULT_LO = HASH_MULT[SLOT_W-1:0];

	typedef struct packed {
		logic              valid;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [DIST_W-1:0] best_d;
		logic [PAL_W-1:0]  best_idx;
	} epi_query_t;

	typedef struct packed {
		logic              en;
		logic [PAL_W-1:0]  idx;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} epi_pal_wr_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [COLOR_W-1:0] color;
		logic [IDX_W-1:0]   entry;
	} epi_slot_t;

endpackage

// File: src/epi_if.sv
`timescale 1ns / 1ps

interface epi_pixel_if;
	logic       valid;
	logic       ready;
	logic       start_frame;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output start_frame, output red, output green, output blue,
		input ready);
	modport sink (input valid, input start_frame, input red, input green, input blue,
		output ready);
endinterface

interface epi_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] palette_index;
	logic       is_new;
	logic       approximated;
	logic [8:0] color_count;

	modport source (output valid, output palette_index, output is_new, output approximated,
		output color_count, input ready);
	modport sink (input valid, input palette_index, input is_new, input approximated,
		input color_count, output ready);
endinterface

// File: src/epi_cell.sv
`timescale 1ns / 1ps

module epi_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [epi_pkg::PAL_W-1:0] cell_idx,
	input  epi_pkg::epi_pal_wr_t     pal_wr,
	input  epi_pkg::epi_query_t      q_in,
	output epi_pkg::epi_query_t      q_out
);
	import epi_pkg::*;

	logic [CHAN_W-1:0] pal_r_q;
	logic [CHAN_W-1:0] pal_g_q;
	logic [CHAN_W-1:0] pal_b_q;
	logic signed [CHAN_W:0]     dr;
	logic signed [CHAN_W:0]     dg;
	logic signed [CHAN_W:0]     db;
	logic signed [2*CHAN_W+1:0] sq_r;
	logic signed [2*CHAN_W+1:0] sq_g;
	logic signed [2*CHAN_W+1:0] sq_b;
	logic [DIST_W-1:0] d;
	epi_query_t q_s1;

	always_ff @(posedge clk) begin
		if (pal_wr.en && pal_wr.idx == cell_idx) begin
			pal_r_q <= pal_wr.red;
			pal_g_q <= pal_wr.green;
			pal_b_q <= pal_wr.blue;
		end
	end

	assign dr   = $signed({1'b0, pal_r_q}) - $signed({1'b0, q_in.red});
	assign dg   = $signed({1'b0, pal_g_q}) - $signed({1'b0, q_in.green});
	assign db   = $signed({1'b0, pal_b_q}) - $signed({1'b0, q_in.blue});
	assign sq_r = dr * dr;
	assign sq_g = dg * dg;
	assign sq_b = db * db;
	assign d    = DIST_W'($unsigned(sq_r)) + DIST_W'($unsigned(sq_g))
		+ DIST_W'($unsigned(sq_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_s1 <= '0;
		end else begin
			q_s1.valid <= q_in.valid;
			q_s1.red   <= q_in.red;
			q_s1.green <= q_in.green;
			q_s1.blue  <= q_in.blue;
			if (d < q_in.best_d) begin
				q_s1.best_d   <= d;
				q_s1.best_idx <= cell_idx;
			end else begin
				q_s1.best_d   <= q_in.best_d;
				q_s1.best_idx <= q_in.best_idx;
			end
		end
	end

	assign q_out = q_s1;

endmodule

// File: src/epi_chain.sv
`timescale 1ns / 1ps

module epi_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  epi_pkg::epi_pal_wr_t pal_wr,
	input  epi_pkg::epi_query_t  launch,
	output epi_pkg::epi_query_t  q_out
);
	import epi_pkg::*;

	epi_query_t link [PALETTE_ENTRIES+1];

	assign link[0] = launch;

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		epi_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (PAL_W'(i)),
			.pal_wr   (pal_wr),
			.q_in     (link[i]),
			.q_out    (link[i+1])
		);
	end

	assign q_out = link[PALETTE_ENTRIES];

endmodule

// File: src/exact_palette_indexer_unit.sv
// Known color: probe reads the hash slot, look checks it, emit registers the result word.
// Extra probes repeat look. New color: same steps; the palette cell and the slot are written in place.
// Full palette, unknown color: plus a pass through the registered chain of palette cells.
// One pixel at a time; the next pixel is taken while the last result word waits.
// After reset the 4096-slot hash table is wiped slot by slot with pixel ready low;
// the same wipe runs once every 255 frames when the frame tag wraps.
`timescale 1ns / 1ps

module exact_palette_indexer_unit (
	input  logic         clk,
	input  logic         arst_n,
	epi_pixel_if.sink    pixel,
	epi_result_if.source result
);
	import epi_pkg::*;

	typedef enum logic [2:0] {
		ST_WIPE,
		ST_IDLE,
		ST_PROBE,
		ST_LOOK,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   wipe_q;
	logic                pend_q;
	logic [EPOCH_W-1:0]  epoch_q;
	logic [COUNT_W-1:0]  count_q;
	logic [COLOR_W-1:0]  color_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic                res_new_q;
	logic                res_apx_q;
	logic                out_valid_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic                out_new_q;
	logic                out_apx_q;
	logic [CNT_W-1:0]    out_cnt_q;

	epi_slot_t           slot_mem [HASH_SLOTS];
	epi_slot_t           rd_q;
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_wa;
	logic [SLOT_W-1:0]   mem_ra;
	epi_slot_t           mem_wd;

	logic [COLOR_W-1:0]  in_color;
	logic [SLOT_W-1:0]   in_slot;
	logic                in_take;
	logic                hit;
	logic                match;
	logic                full;
	logic                add;
	logic                miss_full;
	logic                out_free;

	epi_pal_wr_t         pal_wr;
	epi_query_t          launch;
	epi_query_t          chain_out;

	assign in_color  = {pixel.red, pixel.green, pixel.blue};
	assign in_slot   = in_color[SLOT_W-1:0] * HASH_MULT_LO;
	assign pixel.ready = (state_q == ST_IDLE);
	assign in_take   = pixel.valid && pixel.ready;

	assign hit       = (rd_q.epoch == epoch_q);
	assign match     = hit && (rd_q.color == color_q);
	assign full      = (count_q == COUNT_W'(PALETTE_ENTRIES));
	assign add       = (state_q == ST_LOOK) && !hit && !full;
	assign miss_full = (state_q == ST_LOOK) && !hit && full;
	assign out_free  = !out_valid_q || result.ready;

	assign mem_we = (state_q == ST_WIPE) || add;
	assign mem_wa = (state_q == ST_WIPE) ? wipe_q : slot_q;
	assign mem_ra = (state_q == ST_LOOK) ? slot_q + SLOT_W'(1) : slot_q;
	always_comb begin
		mem_wd = '0;
		if (state_q != ST_WIPE) begin
			mem_wd.epoch = epoch_q;
			mem_wd.color = color_q;
			mem_wd.entry = IDX_W'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_wa] <= mem_wd;
		end
		rd_q <= slot_mem[mem_ra];
	end

	assign pal_wr.en    = add;
	assign pal_wr.idx   = PAL_W'(count_q);
	assign pal_wr.red   = color_q[3*CHAN_W-1:2*CHAN_W];
	assign pal_wr.green = color_q[2*CHAN_W-1:CHAN_W];
	assign pal_wr.blue  = color_q[CHAN_W-1:0];

	assign launch.valid    = miss_full;
	assign launch.red      = color_q[3*CHAN_W-1:2*CHAN_W];
	assign launch.green    = color_q[2*CHAN_W-1:CHAN_W];
	assign launch.blue     = color_q[CHAN_W-1:0];
	assign launch.best_d   = '1;
	assign launch.best_idx = '0;

	epi_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.pal_wr (pal_wr),
		.launch (launch),
		.q_out  (chain_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			wipe_q      <= '0;
			pend_q      <= 1'b0;
			epoch_q     <= EPOCH_W'(1);
			count_q     <= '0;
			color_q     <= '0;
			slot_q      <= '0;
			res_idx_q   <= '0;
			res_new_q   <= 1'b0;
			res_apx_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_new_q   <= 1'b0;
			out_apx_q   <= 1'b0;
			out_cnt_q   <= '0;
		end else begin
			if (out_valid_q && result.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_WIPE: begin
					wipe_q <= wipe_q + SLOT_W'(1);
					if (wipe_q == SLOT_W'(HASH_SLOTS - 1)) begin
						pend_q  <= 1'b0;
						state_q <= pend_q ? ST_PROBE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_take) begin
						color_q <= in_color;
						slot_q  <= in_slot;
						state_q <= ST_PROBE;
						if (pixel.start_frame) begin
							count_q <= '0;
							if (epoch_q == '1) begin
								epoch_q <= EPOCH_W'(1);
								wipe_q  <= '0;
								pend_q  <= 1'b1;
								state_q <= ST_WIPE;
							end else begin
								epoch_q <= epoch_q + EPOCH_W'(1);
							end
						end
					end
				end
				ST_PROBE: begin
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (match) begin
						res_idx_q <= rd_q.entry;
						res_new_q <= 1'b0;
						res_apx_q <= 1'b0;
						state_q   <= ST_EMIT;
					end else if (add) begin
						res_idx_q <= IDX_W'(count_q);
						res_new_q <= 1'b1;
						res_apx_q <= 1'b0;
						count_q   <= count_q + COUNT_W'(1);
						state_q   <= ST_EMIT;
					end else if (miss_full) begin
						state_q <= ST_SEARCH;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				ST_SEARCH: begin
					if (chain_out.valid) begin
						res_idx_q <= IDX_W'(chain_out.best_idx);
						res_new_q <= 1'b0;
						res_apx_q <= 1'b1;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= res_idx_q;
						out_new_q   <= res_new_q;
						out_apx_q   <= res_apx_q;
						out_cnt_q   <= CNT_W'(count_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.palette_index = out_idx_q;
	assign result.is_new        = out_new_q;
	assign result.approximated  = out_apx_q;
	assign result.color_count   = out_cnt_q;

endmodule

// File: src/epi_checker.sv
`timescale 1ns / 1ps

module epi_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] palette_index,
	input logic       is_new,
	input logic       approximated,
	input logic [8:0] color_count
);
	import epi_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(palette_index)
			&& $stable(color_count))
		else $error("result word changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(is_new && approximated))
		else $error("new and approximated together");

	a_apx_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && approximated |-> color_count == CNT_W'(PALETTE_ENTRIES))
		else $error("approximated with palette not full");

	a_new_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_new |-> palette_index == IDX_W'(color_count - 9'd1)
			&& color_count != 9'd0)
		else $error("new entry index does not match count");

endmodule

bind exact_palette_indexer_unit epi_checker u_epi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.palette_index (result.palette_index),
	.is_new        (result.is_new),
	.approximated  (result.approximated),
	.color_count   (result.color_count)
);
